/* hdl/sdx_pkg.sv */
// Shared types, code tables and constants for the soundex word encoder.
// No dependencies; every other file of the block but the checker imports this package.
`default_nettype none

package sdx_pkg;

  // Digit table selection held in the language register.
  typedef enum logic {
    LANG_FRENCH  = 1'b0,
    LANG_ENGLISH = 1'b1
  } sdx_lang_t;

  // Register indexes on the configuration port.
  localparam int unsigned REG_LANGUAGE = 0;
  localparam int unsigned REG_COUNT    = 1;

  // Character constants.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] CHAR_E       = 8'h45;
  localparam logic [7:0] CHAR_I       = 8'h49;
  localparam logic [7:0] CHAR_O       = 8'h4F;
  localparam logic [7:0] CHAR_U       = 8'h55;
  localparam logic [7:0] CHAR_Y       = 8'h59;
  localparam logic [7:0] CHAR_H       = 8'h48;
  localparam logic [7:0] CHAR_W       = 8'h57;

  // Word separators.
  localparam logic [7:0] SEP_NUL    = 8'h00;
  localparam logic [7:0] SEP_SPACE  = 8'h20;
  localparam logic [7:0] SEP_BANG   = 8'h21;
  localparam logic [7:0] SEP_QUOTE  = 8'h27;
  localparam logic [7:0] SEP_LPAREN = 8'h28;
  localparam logic [7:0] SEP_RPAREN = 8'h29;
  localparam logic [7:0] SEP_COMMA  = 8'h2C;
  localparam logic [7:0] SEP_PERIOD = 8'h2E;
  localparam logic [7:0] SEP_COLON  = 8'h3A;
  localparam logic [7:0] SEP_SEMI   = 8'h3B;
  localparam logic [7:0] SEP_QMARK  = 8'h3F;
  localparam logic [7:0] SEP_LBRACK = 8'h5B;
  localparam logic [7:0] SEP_RBRACK = 8'h5D;

  localparam int unsigned LETTER_COUNT = 26;
  localparam int unsigned DIGIT_COUNT  = 3;

  // Digit tables, indexed by letter position from A.
  localparam logic [3:0] FR_TABLE [LETTER_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd9, 4'd7, 4'd0, 4'd0, 4'd7, 4'd2, 4'd4, 4'd5,
    4'd5, 4'd0, 4'd1, 4'd2, 4'd6, 4'd8, 4'd3, 4'd0, 4'd9, 4'd0, 4'd8, 4'd0, 4'd8
  };
  localparam logic [3:0] EN_TABLE [LETTER_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd5,
    4'd5, 4'd0, 4'd1, 4'd2, 4'd6, 4'd2, 4'd3, 4'd0, 4'd1, 4'd0, 4'd2, 4'd0, 4'd2
  };

  // One input character as held in the input register.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } sdx_item_t;

  // Classification of one character.
  typedef struct packed {
    logic       separator;
    logic       letter;
    logic       consonant;
    logic [7:0] upper;
    logic [3:0] code;
  } sdx_class_t;

  // One code word.
  typedef struct packed {
    logic [7:0] first_letter;
    logic [3:0] digit_one;
    logic [3:0] digit_two;
    logic [3:0] digit_three;
    logic       word_valid;
  } sdx_result_t;

endpackage

`default_nettype wire

/* hdl/sdx_char_class.sv */
// Character classifier: separator test, case folding, letter test and digit lookup.
// Depends on sdx_pkg for the tables and character constants.
`default_nettype none

module sdx_char_class
  import sdx_pkg::*;
(
  input  wire logic [7:0] ch,
  input  sdx_lang_t       language,
  output sdx_class_t      cls
);

  logic [7:0] upper;
  logic       letter;
  logic [4:0] index;
  logic       separator;
  logic       plain_vowel;
  logic [3:0] code;

  always_comb begin
    separator = 1'b0;
    case (ch)
      SEP_NUL, SEP_SPACE, SEP_BANG, SEP_QUOTE, SEP_LPAREN, SEP_RPAREN, SEP_COMMA,
      SEP_PERIOD, SEP_COLON, SEP_SEMI, SEP_QMARK, SEP_LBRACK, SEP_RBRACK: begin
        separator = 1'b1;
      end
      default: begin
        separator = 1'b0;
      end
    endcase
  end

  assign upper  = (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ? ch - CASE_OFFSET : ch;
  assign letter = (upper >= CHAR_UPPER_A) && (upper <= CHAR_UPPER_Z);
  assign index  = 5'(upper - CHAR_UPPER_A);

  // Letters that never add a digit.
  assign plain_vowel = (upper == CHAR_UPPER_A) || (upper == CHAR_E) || (upper == CHAR_I) ||
                       (upper == CHAR_O) || (upper == CHAR_U) || (upper == CHAR_Y) ||
                       (upper == CHAR_H) || (upper == CHAR_W);

  always_comb begin
    code = 4'd0;
    if (letter) begin
      case (language)
        LANG_ENGLISH: code = EN_TABLE[index];
        LANG_FRENCH:  code = FR_TABLE[index];
        default:      code = FR_TABLE[index];
      endcase
    end
  end

  assign cls.separator = separator;
  assign cls.letter    = letter;
  assign cls.consonant = letter && !plain_vowel;
  assign cls.upper     = upper;
  assign cls.code      = code;

endmodule

`default_nettype wire

/* hdl/sdx_word_state.sv */
// Word state and result register: tracks the current word and builds its code.
// Depends on sdx_pkg and on sdx_char_class for the character decode.
`default_nettype none

module sdx_word_state
  import sdx_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  sdx_lang_t  language,
  input  wire logic  step,
  input  sdx_item_t  item,
  input  wire logic  result_taken,
  output logic       result_valid,
  output sdx_result_t result
);

  sdx_class_t  cls;

  logic        inside_word;
  logic        inside_word_next;
  logic [7:0]  held_first_letter;
  logic [7:0]  held_first_letter_next;
  logic [3:0]  code_digit_store [DIGIT_COUNT];
  logic [3:0]  code_digit_store_next [DIGIT_COUNT];
  logic [1:0]  digits_taken;
  logic [1:0]  digits_taken_next;
  logic [3:0]  previous_code;
  logic [3:0]  previous_code_next;
  logic        bad_character_seen;
  logic        bad_character_seen_next;
  logic        result_valid_next;
  sdx_result_t result_next;
  logic        word_end;

  sdx_char_class u_class (
    .ch       (item.ch),
    .language (language),
    .cls      (cls)
  );

  assign word_end = item.end_of_text || cls.separator;

  always_comb begin
    inside_word_next        = inside_word;
    held_first_letter_next  = held_first_letter;
    code_digit_store_next   = code_digit_store;
    digits_taken_next       = digits_taken;
    previous_code_next      = previous_code;
    bad_character_seen_next = bad_character_seen;
    result_valid_next       = result_valid && !result_taken;
    result_next             = result;

    if (step) begin
      if (word_end) begin
        if (inside_word) begin
          inside_word_next  = 1'b0;
          result_valid_next = 1'b1;
          if (bad_character_seen) begin
            result_next = '0;
          end else begin
            result_next.first_letter = held_first_letter;
            result_next.digit_one    = code_digit_store[0];
            result_next.digit_two    = code_digit_store[1];
            result_next.digit_three  = code_digit_store[2];
            result_next.word_valid   = 1'b1;
          end
        end
      end else if (!inside_word) begin
        inside_word_next        = 1'b1;
        held_first_letter_next  = cls.upper;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          code_digit_store_next[i] = 4'd0;
        end
        digits_taken_next       = 2'd0;
        bad_character_seen_next = !cls.letter;
        previous_code_next      = cls.code;
      end else begin
        if (!cls.letter) begin
          bad_character_seen_next = 1'b1;
        end
        if ((digits_taken < 2'(DIGIT_COUNT)) && cls.consonant && (cls.code != previous_code))
        begin
          for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (digits_taken == 2'(i)) begin
              code_digit_store_next[i] = cls.code;
            end
          end
          digits_taken_next = digits_taken + 2'd1;
        end
        previous_code_next = cls.code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word        <= 1'b0;
      held_first_letter  <= 8'd0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        code_digit_store[i] <= 4'd0;
      end
      digits_taken       <= 2'd0;
      previous_code      <= 4'd0;
      bad_character_seen <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      inside_word        <= inside_word_next;
      held_first_letter  <= held_first_letter_next;
      code_digit_store   <= code_digit_store_next;
      digits_taken       <= digits_taken_next;
      previous_code      <= previous_code_next;
      bad_character_seen <= bad_character_seen_next;
      result_valid       <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire

/* hdl/soundex_word_encoder_unit.sv */
// Top level of the soundex word encoder: stream ports, input register, configuration port.
// Depends on sdx_pkg, sdx_word_state and sdx_char_class.
//
//   Port group   Role                 Contents
//   s_*          character stream in  tdata = ch, tlast = end_of_text
//   m_*          code stream out      tdata = first letter and three digits, tuser = word_valid
//   APB          configuration        register 0 (byte address 0) = language
//
// Each character request is captured in an input register and from there passes
// through the classifier and the word state logic into the result register.
// An accepted separator passes through both registers to its code word on the output.
// A new character is taken in every cycle unless stalled. The two registers form a
// two-stage pipeline, so a stalled output only stops intake once both stages are full.
// Reset is synchronous and clears the word state, the language register and both
// valid flags; there is no clearing pass.
`default_nettype none

module soundex_word_encoder_unit
  import sdx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Character stream in.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ch
  input  wire logic        s_tlast,   // end_of_text
  // Code stream out.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] first_letter, [11:8] digit_one,
                                      // [15:12] digit_two, [19:16] digit_three, zero pad
  output logic [0:0]       m_tuser,   // [0] word_valid
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  sdx_lang_t   language;
  sdx_lang_t   language_next;
  logic        reg_index;
  logic        cfg_write;

  logic        in_valid;
  logic        in_valid_next;
  sdx_item_t   in_item;
  logic        advance;
  logic        step;
  sdx_result_t result;
  logic        result_valid;

  // Configuration: the word index is the byte address divided by four.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    language_next = language;
    if (cfg_write && (reg_index == 1'(REG_LANGUAGE))) begin
      language_next = sdx_lang_t'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_index == 1'(REG_LANGUAGE)) begin
      prdata = {31'd0, language};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      language <= LANG_FRENCH;
    end else begin
      language <= language_next;
    end
  end

  // The input stage moves on whenever the result register is free or being emptied.
  assign advance  = !result_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_comb begin
    in_valid_next = in_valid;
    if (s_tvalid && s_tready) begin
      in_valid_next = 1'b1;
    end else if (advance) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.ch          <= s_tdata;
      in_item.end_of_text <= s_tlast;
    end
  end

  sdx_word_state u_word (
    .clk          (clk),
    .rst          (rst),
    .language     (language),
    .step         (step),
    .item         (in_item),
    .result_taken (m_tready),
    .result_valid (result_valid),
    .result       (result)
  );

  assign m_tvalid   = result_valid;
  assign m_tdata    = {4'd0, result.digit_three, result.digit_two, result.digit_one,
                       result.first_letter};
  assign m_tuser[0] = result.word_valid;

endmodule

`default_nettype wire

/* hdl/sdx_checker.sv */
// Port-level checks for the soundex word encoder, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module sdx_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // No code word is offered right after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("code word offered after reset");

  // A stalled code word holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled code word changed");

  // An invalid word carries an all-zero code.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
    else $error("invalid word with nonzero code");

  // Digits are decimal.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:8] <= 4'd9) && (m_tdata[15:12] <= 4'd9) &&
                 (m_tdata[19:16] <= 4'd9) && (m_tdata[23:20] == 4'd0))
    else $error("code digit out of range");

  // A new code word follows a character request accepted earlier.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("code word without a preceding character request");

endmodule

bind soundex_word_encoder_unit sdx_checker u_sdx_checker (.*);

`default_nettype wire
